@@ hw/rtl/sdst_pkg.sv @@
package sdst_pkg;

  // default session table size
  localparam int SESSION_SLOTS_DEF = 8;

  localparam int IP_W        = 32;
  localparam int PORT_W      = 16;
  localparam int PEER_W      = IP_W + PORT_W;
  localparam int SEQ_W       = 32;
  localparam int SLOT_USED_W = 3;

  typedef enum logic [1:0] {
    OC_ACCEPT = 2'd0,
    OC_DUP    = 2'd1,
    OC_AHEAD  = 2'd2,
    OC_FULL   = 2'd3
  } outcome_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_CMP,
    ST_COMMIT
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic load;    // capture the input transfer
    logic clr;     // restart the table scan
    logic rd;      // read the entry under the scan index
    logic cmp;     // evaluate the entry read last cycle
    logic step;    // advance the scan index
    logic commit;  // update the table and load the result register
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic hit;       // entry under evaluation belongs to the sender
    logic scan_end;  // scan index is on the last slot
    logic out_busy;  // result register still holds an untaken result
  } dp_sts_t;

endpackage

@@ hw/rtl/sdst_ram.sv @@
module sdst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/sdst_datapath.sv @@
module sdst_datapath #(
  parameter int SESSION_SLOTS = sdst_pkg::SESSION_SLOTS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  sdst_pkg::ctrl_cmd_t                   cmd_i,
  output sdst_pkg::dp_sts_t                     sts_o,
  input  logic [sdst_pkg::IP_W-1:0]             src_ip_i,
  input  logic [sdst_pkg::PORT_W-1:0]           src_port_i,
  input  logic signed [sdst_pkg::SEQ_W-1:0]     seq_id_i,
  input  logic                                  final_flag_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output sdst_pkg::outcome_e                    outcome_o,
  output logic                                  send_ack_o,
  output logic signed [sdst_pkg::SEQ_W-1:0]     ack_id_o,
  output logic [sdst_pkg::SLOT_USED_W-1:0]      slot_used_o
);

  import sdst_pkg::*;

  localparam int SLOT_W  = (SESSION_SLOTS > 1) ? $clog2(SESSION_SLOTS) : 1;
  localparam int ENTRY_W = PEER_W + SEQ_W;

  // captured header
  logic [PEER_W-1:0]       peer_q;
  logic signed [SEQ_W-1:0] seq_q;
  logic                    fin_q;

  // scan state
  logic [SLOT_W-1:0] idx_q, idx_d;
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic              hit_q, hit_d;
  logic              free_q, free_d;
  logic [SEQ_W-1:0]  last_q, last_d;

  logic [SESSION_SLOTS-1:0] active_q, active_d;

  // result register
  logic                    out_valid_q, out_valid_d;
  outcome_e                outcome_q, outcome_d;
  logic                    send_ack_q, send_ack_d;
  logic signed [SEQ_W-1:0] ack_id_q, ack_id_d;
  logic [SLOT_W-1:0]       slot_used_q, slot_used_d;

  logic [ENTRY_W-1:0] rdata;
  logic [ENTRY_W-1:0] wdata;
  logic               we;
  logic               match;

  // decision signals
  logic [SEQ_W-1:0] last_v;
  logic [SEQ_W:0]   last_ext, next_ext, seq_ext;
  logic             is_next, is_dup, full;
  logic [SEQ_W-1:0] new_last;

  sdst_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SESSION_SLOTS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (slot_q),
    .wdata_i (wdata),
    .re_i    (cmd_i.rd),
    .raddr_i (idx_q),
    .rdata_o (rdata)
  );

  assign match = active_q[idx_q] && (rdata[ENTRY_W-1:SEQ_W] == peer_q);

  assign sts_o.hit      = match;
  assign sts_o.scan_end = (idx_q == SLOT_W'(SESSION_SLOTS - 1));
  assign sts_o.out_busy = out_valid_q && !out_ready_i;

  // a slot that is not active is treated as holding a stored id of zero
  assign last_v   = hit_q ? last_q : '0;
  assign last_ext = {last_v[SEQ_W-1], last_v};
  assign next_ext = last_ext + (SEQ_W+1)'(1);
  assign seq_ext  = {seq_q[SEQ_W-1], seq_q};
  assign is_next  = (seq_ext == next_ext);
  assign is_dup   = (seq_q <= $signed(last_v));
  assign full     = !hit_q && !free_q;
  assign new_last = is_next ? (fin_q ? '0 : seq_q) : last_v;

  assign we    = cmd_i.commit && !full;
  assign wdata = {peer_q, new_last};

  always_comb begin
    idx_d       = idx_q;
    slot_d      = slot_q;
    hit_d       = hit_q;
    free_d      = free_q;
    last_d      = last_q;
    active_d    = active_q;
    out_valid_d = out_valid_q;
    outcome_d   = outcome_q;
    send_ack_d  = send_ack_q;
    ack_id_d    = ack_id_q;
    slot_used_d = slot_used_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    if (cmd_i.clr) begin
      idx_d  = '0;
      hit_d  = 1'b0;
      free_d = 1'b0;
    end

    if (cmd_i.cmp) begin
      if (match) begin
        hit_d  = 1'b1;
        slot_d = idx_q;
        last_d = rdata[SEQ_W-1:0];
      end else if (!active_q[idx_q] && !free_q) begin
        free_d = 1'b1;
        slot_d = idx_q;
      end
    end

    if (cmd_i.step) begin
      idx_d = idx_q + SLOT_W'(1);
    end

    if (cmd_i.commit) begin
      out_valid_d = 1'b1;
      if (full) begin
        outcome_d   = OC_FULL;
        send_ack_d  = 1'b0;
        ack_id_d    = '0;
        slot_used_d = '0;
      end else begin
        slot_used_d      = slot_q;
        active_d[slot_q] = !(is_next && fin_q);
        if (is_next) begin
          outcome_d  = OC_ACCEPT;
          send_ack_d = 1'b1;
          ack_id_d   = seq_q;
        end else if (is_dup) begin
          outcome_d  = OC_DUP;
          send_ack_d = 1'b1;
          ack_id_d   = seq_q;
        end else begin
          outcome_d  = OC_AHEAD;
          send_ack_d = 1'b0;
          ack_id_d   = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= '0;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
      hit_q       <= 1'b0;
      free_q      <= 1'b0;
    end else begin
      active_q    <= active_d;
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
      hit_q       <= hit_d;
      free_q      <= free_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      peer_q <= {src_ip_i, src_port_i};
      seq_q  <= seq_id_i;
      fin_q  <= final_flag_i;
    end
    slot_q      <= slot_d;
    last_q      <= last_d;
    outcome_q   <= outcome_d;
    send_ack_q  <= send_ack_d;
    ack_id_q    <= ack_id_d;
    slot_used_q <= slot_used_d;
  end

  assign out_valid_o = out_valid_q;
  assign outcome_o   = outcome_q;
  assign send_ack_o  = send_ack_q;
  assign ack_id_o    = ack_id_q;
  assign slot_used_o = SLOT_USED_W'(slot_used_q);

endmodule

@@ hw/rtl/sdst_ctrl.sv @@
module sdst_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  sdst_pkg::dp_sts_t   sts_i,
  output sdst_pkg::ctrl_cmd_t cmd_o
);

  import sdst_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          cmd_o.clr  = 1'b1;
          state_d    = ST_READ;
        end
      end
      ST_READ: begin
        cmd_o.rd = 1'b1;
        state_d  = ST_CMP;
      end
      ST_CMP: begin
        cmd_o.cmp = 1'b1;
        if (sts_i.hit || sts_i.scan_end) begin
          state_d = ST_COMMIT;
        end else begin
          cmd_o.step = 1'b1;
          state_d    = ST_READ;
        end
      end
      ST_COMMIT: begin
        // hold until the result register is free
        if (!sts_i.out_busy) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

@@ hw/rtl/sequenced_datagram_session_tracker.sv @@
// session tracker for a stop-and-wait datagram receiver
// input channel (in_valid_i / in_ready_o): one received header per transfer,
//   sender address and port, signed sequence id and the final flag
// output channel (out_valid_o / out_ready_i): one result per header, giving
//   the outcome code, whether an ack goes out, the acked id and the slot
// a header is looked up by walking the session table one slot at a time
//   (registered table read, then compare), stopping at the sender's slot;
//   otherwise the lowest free slot is claimed, or table full is reported
// one header is handled at a time; in_ready_o rises again once the result
//   has been loaded into the output register
// a stalled receiver holds the result in the output register, and the next
//   header's scan runs meanwhile but waits before its commit step
// reset marks every session slot inactive (an inactive slot is treated as
//   holding a stored id of zero) and empties the output register; no
//   clearing pass over the table is needed
module sequenced_datagram_session_tracker #(
  parameter int SESSION_SLOTS = sdst_pkg::SESSION_SLOTS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // header input
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [sdst_pkg::IP_W-1:0]             src_ip_i,
  input  logic [sdst_pkg::PORT_W-1:0]           src_port_i,
  input  logic signed [sdst_pkg::SEQ_W-1:0]     seq_id_i,
  input  logic                                  final_flag_i,
  // result output
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [1:0]                            outcome_o,
  output logic                                  send_ack_o,
  output logic signed [sdst_pkg::SEQ_W-1:0]     ack_id_o,
  output logic [sdst_pkg::SLOT_USED_W-1:0]      slot_used_o
);

  import sdst_pkg::*;

  ctrl_cmd_t cmd;
  dp_sts_t   sts;
  outcome_e  outcome;

  // sequencing of the lookup, claim and commit steps
  sdst_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // session table, sequence checks and result register
  sdst_datapath #(
    .SESSION_SLOTS (SESSION_SLOTS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .src_ip_i     (src_ip_i),
    .src_port_i   (src_port_i),
    .seq_id_i     (seq_id_i),
    .final_flag_i (final_flag_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .outcome_o    (outcome),
    .send_ack_o   (send_ack_o),
    .ack_id_o     (ack_id_o),
    .slot_used_o  (slot_used_o)
  );

  assign outcome_o = 2'(outcome);

endmodule
